// File: rtl/i2cs_pkg.sv
// ----------------------------------------------------------------------------
// i2cs_pkg
// Shared types, codes and sizes of the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cs_pkg;

    // Transmit store geometry
    localparam int BUFFER_DEPTH = 32;
    localparam int BUF_AW       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W        = 6;

    // Input operations
    localparam logic [1:0] OP_QUEUE       = 2'd0;
    localparam logic [1:0] OP_START_WRITE = 2'd1;
    localparam logic [1:0] OP_START_READ  = 2'd2;
    localparam logic [1:0] OP_EVENT       = 2'd3;

    // Bus modes
    localparam logic [1:0] MODE_READY = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // Bus actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_SEND    = 3'd2;
    localparam logic [2:0] ACT_ACK     = 3'd3;
    localparam logic [2:0] ACT_NACK    = 3'd4;
    localparam logic [2:0] ACT_STOP    = 3'd5;
    localparam logic [2:0] ACT_RELEASE = 3'd6;

    // Completion codes
    localparam logic [2:0] RES_OK        = 3'd0;
    localparam logic [2:0] RES_ADDR_NACK = 3'd1;
    localparam logic [2:0] RES_DATA_NACK = 3'd2;
    localparam logic [2:0] RES_OTHER     = 3'd3;
    localparam logic [2:0] RES_REJECTED  = 3'd4;

    // TWI status codes, low three bits masked
    localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_REP_START   = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST    = 8'h38;
    localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
    localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       data_byte;
        logic [6:0]       target_address;
        logic [7:0]       transfer_length;
        logic [7:0]       status_code;
    } i2cs_item_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [7:0]       addr_dir;
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] limit;
        logic [2:0]       err;
    } i2cs_state_t;

    typedef struct packed {
        logic [2:0]       bus_action;
        logic [7:0]       out_byte;
        logic [7:0]       rx_byte;
        logic             rx_valid;
        logic             busy_res;
        logic             done_res;
        logic [2:0]       result_code;
        logic [CNT_W-1:0] byte_count;
    } i2cs_result_t;

    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } i2cs_wr_t;

endpackage

// File: rtl/i2cs_step.sv
// ----------------------------------------------------------------------------
// i2cs_step
// Decision logic for one transaction: next sequencer state, bus action and
// report, plus the transmit store write for queued bytes.
// ----------------------------------------------------------------------------
module i2cs_step (
    input  i2cs_pkg::i2cs_item_t   item,
    input  i2cs_pkg::i2cs_state_t  st,
    input  logic [7:0]             store_rd_data,
    output i2cs_pkg::i2cs_state_t  st_next,
    output i2cs_pkg::i2cs_result_t res,
    output i2cs_pkg::i2cs_wr_t     wr
);
    import i2cs_pkg::*;

    logic [7:0]       code;
    logic             is_wr;
    logic             fin;
    logic [CNT_W:0]   pos_inc;
    logic [CNT_W-1:0] len_clamped;

    assign code  = {item.status_code[7:3], 3'b000};
    assign is_wr = (st.mode == MODE_WRITE);

    // Clamp the read length to the store depth
    always_comb begin
        if (item.transfer_length > 8'(BUFFER_DEPTH)) begin
            len_clamped = CNT_W'(BUFFER_DEPTH);
        end else begin
            len_clamped = item.transfer_length[CNT_W-1:0];
        end
    end

    // Decide the next state and the report
    always_comb begin
        st_next = st;
        res     = '0;
        wr.en   = 1'b0;
        wr.addr = st.fill[BUF_AW-1:0];
        wr.data = item.data_byte;
        fin     = 1'b0;
        pos_inc = '0;

        unique case (item.op)
            OP_QUEUE: begin
                if (st.mode == MODE_READY && st.fill < CNT_W'(BUFFER_DEPTH)) begin
                    wr.en        = 1'b1;
                    st_next.fill = st.fill + 1'b1;
                end
            end
            OP_START_WRITE, OP_START_READ: begin
                if (st.mode != MODE_READY ||
                    (item.op == OP_START_READ && item.transfer_length == 8'd0)) begin
                    res.done_res    = 1'b1;
                    res.result_code = RES_REJECTED;
                end else begin
                    if (item.op == OP_START_WRITE) begin
                        st_next.mode     = MODE_WRITE;
                        st_next.addr_dir = {item.target_address, 1'b0};
                        st_next.limit    = st.fill;
                        st_next.fill     = '0;
                    end else begin
                        st_next.mode     = MODE_READ;
                        st_next.addr_dir = {item.target_address, 1'b1};
                        st_next.limit    = len_clamped;
                    end
                    st_next.pos    = '0;
                    st_next.err    = RES_OK;
                    res.bus_action = ACT_START;
                end
            end
            OP_EVENT: begin
                if (st.mode != MODE_READY) begin
                    unique case (code)
                        ST_START, ST_REP_START: begin
                            res.bus_action = ACT_SEND;
                            res.out_byte   = st.addr_dir;
                        end
                        ST_SLA_W_ACK, ST_DATA_W_ACK: begin
                            if (is_wr) begin
                                if (st.pos < st.limit && st.pos < CNT_W'(BUFFER_DEPTH)) begin
                                    res.bus_action = ACT_SEND;
                                    res.out_byte   = store_rd_data;
                                    st_next.pos    = st.pos + 1'b1;
                                end else begin
                                    res.bus_action = ACT_STOP;
                                    fin            = 1'b1;
                                end
                            end
                        end
                        ST_SLA_W_NACK, ST_DATA_W_NACK: begin
                            if (is_wr) begin
                                st_next.err    = (code == ST_SLA_W_NACK) ? RES_ADDR_NACK
                                                                         : RES_DATA_NACK;
                                res.bus_action = ACT_STOP;
                                fin            = 1'b1;
                            end
                        end
                        ST_ARB_LOST: begin
                            st_next.err    = RES_OTHER;
                            res.bus_action = ACT_RELEASE;
                            fin            = 1'b1;
                        end
                        ST_DATA_R_ACK, ST_SLA_R_ACK: begin
                            if (!is_wr) begin
                                if (code == ST_DATA_R_ACK) begin
                                    res.rx_byte  = item.data_byte;
                                    res.rx_valid = 1'b1;
                                    if (st.pos < st.limit) begin
                                        st_next.pos = st.pos + 1'b1;
                                    end
                                end
                                pos_inc = {1'b0, st_next.pos} + 1'b1;
                                res.bus_action = (pos_inc < {1'b0, st.limit}) ? ACT_ACK
                                                                              : ACT_NACK;
                            end
                        end
                        ST_DATA_R_NACK, ST_SLA_R_NACK: begin
                            if (!is_wr) begin
                                if (code == ST_DATA_R_NACK) begin
                                    res.rx_byte  = item.data_byte;
                                    res.rx_valid = 1'b1;
                                    if (st.pos < st.limit) begin
                                        st_next.pos = st.pos + 1'b1;
                                    end
                                end
                                res.bus_action = ACT_STOP;
                                fin            = 1'b1;
                            end
                        end
                        ST_BUS_ERROR: begin
                            st_next.err    = RES_OTHER;
                            res.bus_action = ACT_STOP;
                            fin            = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        // Close the transaction and report its outcome
        if (fin) begin
            st_next.mode    = MODE_READY;
            res.done_res    = 1'b1;
            res.result_code = st_next.err;
            res.byte_count  = st_next.pos;
        end
        res.busy_res = (st_next.mode != MODE_READY);
    end

endmodule

// File: rtl/i2c_master_transaction_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Sequences I2C master transactions from queue, start and bus status items.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the result register is free
// or drained, and returns one result for each, from the input register through
// the result register. The input register can still take one item while a
// result waits to be taken, so one item can be held behind a stalled result.
// The 32-byte transmit store is a memory with a registered read port; the byte
// at the current send position is fetched ahead of time, so a data send does
// not wait for the store read. The store is not cleared at reset: only bytes
// queued since reset or the last write start are ever sent.
module i2c_master_transaction_sequencer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic [7:0]                 s_data_byte,
    input  logic [6:0]                 s_target_address,
    input  logic [7:0]                 s_transfer_length,
    input  logic [7:0]                 s_status_code,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_bus_action,
    output logic [7:0]                 m_out_byte,
    output logic [7:0]                 m_rx_byte,
    output logic                       m_rx_valid,
    output logic                       m_busy_res,
    output logic                       m_done_res,
    output logic [2:0]                 m_result_code,
    output logic [i2cs_pkg::CNT_W-1:0] m_byte_count
);
    import i2cs_pkg::*;

    logic         in_valid_reg;
    i2cs_item_t   in_item_reg;
    logic         out_valid_reg;
    i2cs_result_t out_res_reg;
    i2cs_state_t  st_reg;
    i2cs_state_t  st_step;
    i2cs_state_t  st_next;
    i2cs_result_t step_res;
    i2cs_wr_t     step_wr;
    logic         advance;
    logic         fire;
    logic [7:0]   store_mem [BUFFER_DEPTH];
    logic [7:0]   store_rd_reg;

    // Move an item forward when the result register is free or drained
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Hold the input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_item_reg <= '{op: s_op, data_byte: s_data_byte,
                             target_address: s_target_address,
                             transfer_length: s_transfer_length,
                             status_code: s_status_code};
        end
    end

    i2cs_step u_step (
        .item          (in_item_reg),
        .st            (st_reg),
        .store_rd_data (store_rd_reg),
        .st_next       (st_step),
        .res           (step_res),
        .wr            (step_wr)
    );

    assign st_next = fire ? st_step : st_reg;

    // Advance the sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{mode: MODE_READY, addr_dir: 8'd0, fill: '0, pos: '0,
                        limit: '0, err: RES_OK};
        end else begin
            st_reg <= st_next;
        end
    end

    // Write queued bytes; prefetch the byte at the next send position
    always_ff @(posedge aclk) begin
        if (fire && step_wr.en) begin
            store_mem[step_wr.addr] <= step_wr.data;
        end
        store_rd_reg <= store_mem[st_next.pos[BUF_AW-1:0]];
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (fire) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_bus_action  = out_res_reg.bus_action;
    assign m_out_byte    = out_res_reg.out_byte;
    assign m_rx_byte     = out_res_reg.rx_byte;
    assign m_rx_valid    = out_res_reg.rx_valid;
    assign m_busy_res    = out_res_reg.busy_res;
    assign m_done_res    = out_res_reg.done_res;
    assign m_result_code = out_res_reg.result_code;
    assign m_byte_count  = out_res_reg.byte_count;

    // A received byte comes only with an ack, nack or stop decision
    a_rx_action: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rx_valid |->
            (m_bus_action == ACT_ACK || m_bus_action == ACT_NACK ||
             m_bus_action == ACT_STOP))
        else $error("received byte without a read action");

    // Completion code and count are reported only with done
    a_code_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> (m_result_code == RES_OK && m_byte_count == '0))
        else $error("completion report without done");

    // A stalled input transaction stays in place
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("input transaction lost under stall");

    // The send position never passes the transfer limit
    a_pos_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.pos <= st_reg.limit)
        else $error("transfer position beyond limit");

endmodule

// File: verif/i2cs_result_checker.sv
// ----------------------------------------------------------------------------
// i2cs_result_checker
// Watches both channels of the I2C master transaction sequencer, predicts the
// result of every accepted transaction and compares it field by field with
// the result that the block hands out, in order.
// ----------------------------------------------------------------------------
module i2cs_result_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic [7:0]                 s_data_byte,
    input  logic [6:0]                 s_target_address,
    input  logic [7:0]                 s_transfer_length,
    input  logic [7:0]                 s_status_code,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [2:0]                 m_bus_action,
    input  logic [7:0]                 m_out_byte,
    input  logic [7:0]                 m_rx_byte,
    input  logic                       m_rx_valid,
    input  logic                       m_busy_res,
    input  logic                       m_done_res,
    input  logic [2:0]                 m_result_code,
    input  logic [i2cs_pkg::CNT_W-1:0] m_byte_count,
    output int                         mismatch_count,
    output int                         outstanding,
    output int                         results_checked,
    output int                         completions
);
    timeunit 1ns;
    timeprecision 1ps;

    import i2cs_pkg::*;

    localparam int REPORT_LIMIT = 100;

    // Shadow copy of the sequencer state
    logic [1:0]  seq_mode;
    logic [7:0]  seq_addr_dir;
    logic [7:0]  seq_tx_bytes [BUFFER_DEPTH];
    int unsigned seq_fill;
    int unsigned seq_pos;
    int unsigned seq_limit;
    logic [2:0]  seq_err;

    // Predicted bus responses, oldest first
    i2cs_result_t predicted_responses [$];

    int errors    = 0;
    int checked_n = 0;
    int done_n    = 0;

    // Work out the bus response to one transaction and advance the shadow state
    task automatic sequence_bus_step(input i2cs_item_t it, output i2cs_result_t res);
        logic [7:0]  st;
        logic        finish;
        logic        writing;
        int unsigned req_len;
        res     = '0;
        finish  = 1'b0;
        st      = {it.status_code[7:3], 3'b000};
        writing = (seq_mode == MODE_WRITE);
        req_len = it.transfer_length;
        case (it.op)
            OP_QUEUE: begin
                // store bytes only while idle and not full
                if (seq_mode == MODE_READY && seq_fill < BUFFER_DEPTH) begin
                    seq_tx_bytes[seq_fill] = it.data_byte;
                    seq_fill++;
                end
            end
            OP_START_WRITE, OP_START_READ: begin
                if (seq_mode != MODE_READY ||
                    (it.op == OP_START_READ && it.transfer_length == 8'd0)) begin
                    res.done_res    = 1'b1;
                    res.result_code = RES_REJECTED;
                end else begin
                    if (it.op == OP_START_WRITE) begin
                        seq_mode     = MODE_WRITE;
                        seq_addr_dir = {it.target_address, 1'b0};
                        seq_limit    = seq_fill;
                        seq_fill     = 0;
                    end else begin
                        if (req_len > BUFFER_DEPTH)
                            req_len = BUFFER_DEPTH;
                        seq_mode     = MODE_READ;
                        seq_addr_dir = {it.target_address, 1'b1};
                        seq_limit    = req_len;
                    end
                    seq_pos        = 0;
                    seq_err        = RES_OK;
                    res.bus_action = ACT_START;
                end
            end
            default: begin
                // bus status events do nothing while idle
                if (seq_mode != MODE_READY) begin
                    case (st)
                        ST_START, ST_REP_START: begin
                            res.bus_action = ACT_SEND;
                            res.out_byte   = seq_addr_dir;
                        end
                        ST_SLA_W_ACK, ST_DATA_W_ACK: begin
                            if (writing) begin
                                if (seq_pos < seq_limit && seq_pos < BUFFER_DEPTH) begin
                                    res.bus_action = ACT_SEND;
                                    res.out_byte   = seq_tx_bytes[seq_pos];
                                    seq_pos++;
                                end else begin
                                    res.bus_action = ACT_STOP;
                                    finish         = 1'b1;
                                end
                            end
                        end
                        ST_SLA_W_NACK: begin
                            if (writing) begin
                                seq_err        = RES_ADDR_NACK;
                                res.bus_action = ACT_STOP;
                                finish         = 1'b1;
                            end
                        end
                        ST_DATA_W_NACK: begin
                            if (writing) begin
                                seq_err        = RES_DATA_NACK;
                                res.bus_action = ACT_STOP;
                                finish         = 1'b1;
                            end
                        end
                        ST_ARB_LOST: begin
                            seq_err        = RES_OTHER;
                            res.bus_action = ACT_RELEASE;
                            finish         = 1'b1;
                        end
                        ST_DATA_R_ACK, ST_SLA_R_ACK: begin
                            if (!writing) begin
                                if (st == ST_DATA_R_ACK) begin
                                    res.rx_byte  = it.data_byte;
                                    res.rx_valid = 1'b1;
                                    if (seq_pos < seq_limit)
                                        seq_pos++;
                                end
                                // ack until the last byte is due
                                res.bus_action = (seq_pos + 1 < seq_limit) ? ACT_ACK : ACT_NACK;
                            end
                        end
                        ST_DATA_R_NACK, ST_SLA_R_NACK: begin
                            if (!writing) begin
                                if (st == ST_DATA_R_NACK) begin
                                    res.rx_byte  = it.data_byte;
                                    res.rx_valid = 1'b1;
                                    if (seq_pos < seq_limit)
                                        seq_pos++;
                                end
                                res.bus_action = ACT_STOP;
                                finish         = 1'b1;
                            end
                        end
                        ST_BUS_ERROR: begin
                            seq_err        = RES_OTHER;
                            res.bus_action = ACT_STOP;
                            finish         = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        endcase
        // close out the transfer
        if (finish) begin
            seq_mode         = MODE_READY;
            res.done_res     = 1'b1;
            res.result_code  = seq_err;
            res.byte_count   = seq_pos[CNT_W-1:0];
        end
        res.busy_res = (seq_mode != MODE_READY);
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t ns: %s differs, expected %0d, actual %0d",
                         $time, field, want, got);
            else if (errors == REPORT_LIMIT + 1)
                $display("%0t ns: further field reports suppressed", $time);
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge aclk) begin : monitor
        i2cs_item_t   item;
        i2cs_result_t want;
        int           i;
        if (!aresetn) begin
            seq_mode     = MODE_READY;
            seq_addr_dir = '0;
            seq_fill     = 0;
            seq_pos      = 0;
            seq_limit    = 0;
            seq_err      = RES_OK;
            for (i = 0; i < BUFFER_DEPTH; i++)
                seq_tx_bytes[i] = '0;
            predicted_responses.delete();
        end else begin
            // compare the result leaving the block
            if (m_valid && m_ready) begin
                if (predicted_responses.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with no transaction pending, expected none, actual action %0d",
                             $time, m_bus_action);
                end else begin
                    want = predicted_responses.pop_front();
                    checked_n++;
                    check_field("bus_action",  want.bus_action,  m_bus_action);
                    check_field("out_byte",    want.out_byte,    m_out_byte);
                    check_field("rx_byte",     want.rx_byte,     m_rx_byte);
                    check_field("rx_valid",    want.rx_valid,    m_rx_valid);
                    check_field("busy_res",    want.busy_res,    m_busy_res);
                    check_field("done_res",    want.done_res,    m_done_res);
                    check_field("result_code", want.result_code, m_result_code);
                    check_field("byte_count",  want.byte_count,  m_byte_count);
                end
            end
            // predict the transaction entering the block
            if (s_valid && s_ready) begin
                item.op              = s_op;
                item.data_byte       = s_data_byte;
                item.target_address  = s_target_address;
                item.transfer_length = s_transfer_length;
                item.status_code     = s_status_code;
                sequence_bus_step(item, want);
                if (want.done_res)
                    done_n++;
                predicted_responses.push_back(want);
            end
        end
        outstanding     <= predicted_responses.size();
        mismatch_count  <= errors;
        results_checked <= checked_n;
        completions     <= done_n;
    end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the I2C master transaction sequencer with directed and random
// queue, start and bus status transactions under bursty input and stalling
// output, and reports the verdict from the result checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cs_pkg::*;

    localparam int TOTAL_ITEMS = 900;

    logic                aclk;
    logic                aresetn           = 1'b0;
    logic                s_valid           = 1'b0;
    logic                s_ready;
    logic [1:0]          s_op              = OP_QUEUE;
    logic [7:0]          s_data_byte       = '0;
    logic [6:0]          s_target_address  = '0;
    logic [7:0]          s_transfer_length = '0;
    logic [7:0]          s_status_code     = '0;
    logic                m_valid;
    logic                m_ready           = 1'b0;
    logic [2:0]          m_bus_action;
    logic [7:0]          m_out_byte;
    logic [7:0]          m_rx_byte;
    logic                m_rx_valid;
    logic                m_busy_res;
    logic                m_done_res;
    logic [2:0]          m_result_code;
    logic [CNT_W-1:0]    m_byte_count;

    int mismatch_count;
    int outstanding;
    int results_checked;
    int completions;

    int burst_left    = 0;
    int items_offered = 0;
    int filler_items  = 0;

    i2c_master_transaction_sequencer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_data_byte       (s_data_byte),
        .s_target_address  (s_target_address),
        .s_transfer_length (s_transfer_length),
        .s_status_code     (s_status_code),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_bus_action      (m_bus_action),
        .m_out_byte        (m_out_byte),
        .m_rx_byte         (m_rx_byte),
        .m_rx_valid        (m_rx_valid),
        .m_busy_res        (m_busy_res),
        .m_done_res        (m_done_res),
        .m_result_code     (m_result_code),
        .m_byte_count      (m_byte_count)
    );

    i2cs_result_checker result_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_data_byte       (s_data_byte),
        .s_target_address  (s_target_address),
        .s_transfer_length (s_transfer_length),
        .s_status_code     (s_status_code),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_bus_action      (m_bus_action),
        .m_out_byte        (m_out_byte),
        .m_rx_byte         (m_rx_byte),
        .m_rx_valid        (m_rx_valid),
        .m_busy_res        (m_busy_res),
        .m_done_res        (m_done_res),
        .m_result_code     (m_result_code),
        .m_byte_count      (m_byte_count),
        .mismatch_count    (mismatch_count),
        .outstanding       (outstanding),
        .results_checked   (results_checked),
        .completions       (completions)
    );

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Present one transaction and hold it until accepted; idle between bursts
    task automatic offer_item(input logic [1:0] op, input logic [7:0] data,
                              input logic [6:0] addr, input logic [7:0] len,
                              input logic [7:0] status);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid           <= 1'b1;
        s_op              <= op;
        s_data_byte       <= data;
        s_target_address  <= addr;
        s_transfer_length <= len;
        s_status_code     <= status;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_offered++;
    endtask

    // Fully random transaction mixed into the sequences
    task automatic offer_filler();
        filler_items++;
        offer_item(2'($urandom_range(0, 3)), 8'($urandom), 7'($urandom), 8'($urandom),
                   8'($urandom));
    endtask

    // Bus status code with the ignored low bits scrambled
    function automatic logic [7:0] scramble_low_bits(input logic [7:0] st);
        logic [2:0] low;
        low = 3'($urandom_range(0, 7));
        return {st[7:3], low};
    endfunction

    // Reset, directed cases, random sequences, drain and verdict
    initial begin
        int r;
        int nq;
        int sends;
        int k;
        int len;
        int eff;
        logic ending;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // status event while idle, read of length zero
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_START);
        offer_item(OP_START_READ,  8'h00, 7'h7F, 8'h00, 8'h00);
        // two-byte write to the highest address
        offer_item(OP_QUEUE,       8'h00, 7'h00, 8'h00, 8'h00);
        offer_item(OP_QUEUE,       8'hFF, 7'h00, 8'h00, 8'h00);
        offer_item(OP_START_WRITE, 8'h00, 7'h7F, 8'h00, 8'h00);
        // start and queue while busy, receiver code while writing
        offer_item(OP_START_WRITE, 8'h00, 7'h11, 8'h00, 8'h00);
        offer_item(OP_QUEUE,       8'hAA, 7'h00, 8'h00, 8'h00);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_DATA_R_ACK);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_START | 8'h07);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_SLA_W_ACK | 8'h07);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_DATA_W_ACK);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_DATA_W_ACK);
        // read with oversize length, wrong-direction and unknown codes
        offer_item(OP_START_READ,  8'h00, 7'h00, 8'hFF, 8'h00);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_REP_START);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_SLA_W_ACK);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_SLA_R_ACK);
        offer_item(OP_EVENT,       8'hFF, 7'h00, 8'h00, ST_DATA_R_ACK);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, 8'hF8);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_DATA_R_NACK);
        // address nack on a read completes with success
        offer_item(OP_START_READ,  8'h00, 7'h55, 8'h01, 8'h00);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_SLA_R_NACK);
        // empty write refused by the target
        offer_item(OP_START_WRITE, 8'h00, 7'h2A, 8'h00, 8'h00);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_SLA_W_NACK);
        // arbitration lost and bus error
        offer_item(OP_START_READ,  8'h00, 7'h01, 8'h01, 8'h00);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_ARB_LOST);
        offer_item(OP_START_WRITE, 8'h00, 7'h40, 8'h00, 8'h00);
        offer_item(OP_EVENT,       8'h00, 7'h00, 8'h00, ST_BUS_ERROR);

        // random well-formed transfers with errors and filler mixed in
        while (items_offered < TOTAL_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                // write transfer, occasionally overfilling the store
                nq = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
                repeat (nq) offer_item(OP_QUEUE, 8'($urandom), 7'($urandom), 8'($urandom),
                                       8'($urandom));
                offer_item(OP_START_WRITE, 8'($urandom), 7'($urandom_range(0, 127)),
                           8'($urandom), 8'($urandom));
                offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                           scramble_low_bits($urandom_range(0, 1) ? ST_START : ST_REP_START));
                if ($urandom_range(0, 9) == 0) begin
                    offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                               scramble_low_bits(ST_SLA_W_NACK));
                end else begin
                    offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                               scramble_low_bits(ST_SLA_W_ACK));
                    sends  = (nq > BUFFER_DEPTH) ? BUFFER_DEPTH : nq;
                    ending = (sends == 0);
                    k      = 0;
                    while (!ending) begin
                        r = $urandom_range(0, 99);
                        if (r < 5) begin
                            offer_filler();
                        end else if (r < 9) begin
                            offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                                       scramble_low_bits(ST_DATA_W_NACK));
                            ending = 1'b1;
                        end else if (r < 11) begin
                            offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                                       scramble_low_bits(ST_ARB_LOST));
                            ending = 1'b1;
                        end else if (r < 13) begin
                            offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                                       scramble_low_bits(ST_BUS_ERROR));
                            ending = 1'b1;
                        end else begin
                            offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                                       scramble_low_bits(ST_DATA_W_ACK));
                            k++;
                            if (k == sends)
                                ending = 1'b1;
                        end
                    end
                end
            end else if (r < 80) begin
                // read transfer, lengths mostly short
                r = $urandom_range(0, 9);
                if (r == 0)
                    len = 0;
                else if (r == 1)
                    len = $urandom_range(33, 255);
                else if (r == 2)
                    len = BUFFER_DEPTH;
                else
                    len = $urandom_range(1, 8);
                offer_item(OP_START_READ, 8'($urandom), 7'($urandom_range(0, 127)), 8'(len),
                           8'($urandom));
                if (len != 0) begin
                    eff = (len > BUFFER_DEPTH) ? BUFFER_DEPTH : len;
                    offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                               scramble_low_bits($urandom_range(0, 1) ? ST_START : ST_REP_START));
                    if ($urandom_range(0, 9) == 0) begin
                        offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                                   scramble_low_bits(ST_SLA_R_NACK));
                    end else begin
                        offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                                   scramble_low_bits(ST_SLA_R_ACK));
                        ending = 1'b0;
                        k      = 1;
                        while (!ending && k < eff) begin
                            r = $urandom_range(0, 99);
                            if (r < 5) begin
                                offer_filler();
                            end else if (r < 7) begin
                                offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                                           scramble_low_bits(ST_ARB_LOST));
                                ending = 1'b1;
                            end else if (r < 9) begin
                                offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                                           scramble_low_bits(ST_BUS_ERROR));
                                ending = 1'b1;
                            end else begin
                                offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                                           scramble_low_bits(ST_DATA_R_ACK));
                                k++;
                            end
                        end
                        if (!ending) begin
                            // extra data past the requested length
                            if ($urandom_range(0, 9) == 0)
                                offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                                           scramble_low_bits(ST_DATA_R_ACK));
                            offer_item(OP_EVENT, 8'($urandom), 7'($urandom), 8'($urandom),
                                       scramble_low_bits(ST_DATA_R_NACK));
                        end
                    end
                end
            end else begin
                // pure filler
                repeat ($urandom_range(1, 4)) offer_filler();
            end
        end
        s_valid <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Offered %0d transactions (%0d random filler), compared %0d results,",
                 items_offered, filler_items, results_checked);
        $display("of which %0d closed a transfer or refused a start.", completions);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Output backpressure: rotating patterns plus two long hold-offs
    initial begin
        int cyc;
        cyc = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ((cyc >= 300 && cyc < 370) || (cyc >= 1200 && cyc < 1300)) begin
                m_ready <= 1'b0;
            end else begin
                case ((cyc / 150) % 4)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 9) < 7);
                    2:       m_ready <= ($urandom_range(0, 9) < 3);
                    default: m_ready <= ((cyc % 5) != 0);
                endcase
            end
            @(posedge aclk);
            cyc++;
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
